FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the grid walk block.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the reset input is high
`define GWC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("grid walk assertion failed");

// Assertion that is also evaluated across reset
`define GWC_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("grid walk assertion failed");

`endif

FILE: design/gwc_pkg.sv
// Package of the grid random walk block: field widths, codes, control structs,
// direction tables and the direction pick function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gwc_pkg;

   // Field widths of the request, response and register channels
   localparam int KIND_W      = 2;
   localparam int RND_W       = 15;
   localparam int RROW_W      = 6;
   localparam int RCOL_W      = 5;
   localparam int WROW_W      = 6;
   localparam int WCOL_W      = 5;
   localparam int VISIT_W     = 16;
   localparam int MOVE_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int ROW_COUNT_W = 7;
   localparam int COL_COUNT_W = 6;
   localparam int START_ROW_W = 6;
   localparam int START_COL_W = 5;

   // Register reset values
   localparam int ROW_COUNT_RESET = 40;
   localparam int COL_COUNT_RESET = 20;
   localparam int START_ROW_RESET = 0;
   localparam int START_COL_RESET = 0;

   // Width used for all grid geometry compares (covers sizes up to 511)
   localparam int GEO_W    = 9;
   localparam int GRID_MIN = 3;

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_START = 2'd0,
      KIND_STEP  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_COUNT = 2'd0,
      REG_COL_COUNT = 2'd1,
      REG_START_ROW = 2'd2,
      REG_START_COL = 2'd3
   } csr_index_type;

   // Controller states
   typedef enum logic [2:0] {
      S_BOOT_CLEAR  = 3'd0,
      S_IDLE        = 3'd1,
      S_DECODE      = 3'd2,
      S_START_CLEAR = 3'd3,
      S_FETCH       = 3'd4,
      S_LOOK        = 3'd5,
      S_SEND        = 3'd6
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take;       // capture request payload
      logic clear_en;   // write zero at sweep address, advance sweep
      logic start_en;   // latch grid, place walker, reset counters
      logic move_en;    // move walker one step
      logic fetch_en;   // issue visit store read
      logic look_en;    // read data valid, capture tile count
      logic count_en;   // count a visit of the walker tile
      logic out_load;   // load response register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_start;   // captured request is a start
      logic count_item; // captured request counts a visit
      logic sweep_last; // sweep address is the last store entry
      logic out_free;   // response register can take a new response
   } status_type;

   // Direction codes used as bases of the pick
   localparam logic [2:0] DIR_RIGHT = 3'd1;
   localparam logic [2:0] DIR_DOWN  = 3'd3;
   localparam logic [2:0] DIR_LEFT  = 3'd5;
   localparam logic [2:0] DIR_UP    = 3'd7;
   localparam logic [2:0] DIR_MID   = 3'd0;

   // Row and column step per direction, clockwise from up-right
   localparam logic signed [1:0] ROW_DELTA [8] =
      '{-2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1};
   localparam logic signed [1:0] COL_DELTA [8] =
      '{2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0};

   // Sum of hex digits; congruent to the value modulo 3 and modulo 5
   function automatic logic [5:0] nibble_sum(input logic [RND_W-1:0] rnd);
      return 6'(rnd[3:0]) + 6'(rnd[7:4]) + 6'(rnd[11:8]) + 6'(rnd[14:12]);
   endfunction

   // Remainder by 5 of a digit sum (at most 52)
   function automatic logic [2:0] mod5_small(input logic [5:0] s);
      logic [5:0] v;
      v = s;
      if (v >= 6'd40) v = v - 6'd40;
      if (v >= 6'd20) v = v - 6'd20;
      if (v >= 6'd10) v = v - 6'd10;
      if (v >= 6'd5)  v = v - 6'd5;
      return v[2:0];
   endfunction

   // Remainder by 3 of a digit sum (at most 52)
   function automatic logic [1:0] mod3_small(input logic [5:0] s);
      logic [5:0] v;
      v = s;
      if (v >= 6'd48) v = v - 6'd48;
      if (v >= 6'd24) v = v - 6'd24;
      if (v >= 6'd12) v = v - 6'd12;
      if (v >= 6'd6)  v = v - 6'd6;
      if (v >= 6'd3)  v = v - 6'd3;
      return v[1:0];
   endfunction

   // Legal direction for the walker's tile class and random value
   function automatic logic [2:0] pick_dir(input logic top, input logic bottom,
                                           input logic left, input logic right,
                                           input logic [RND_W-1:0] rnd);
      logic [5:0] s;
      logic [2:0] rem5;
      logic [2:0] rem3;
      logic [2:0] base;
      logic [2:0] rem;
      s    = nibble_sum(rnd);
      rem5 = mod5_small(s);
      rem3 = {1'b0, mod3_small(s)};
      if (top && left) begin
         base = DIR_RIGHT; rem = rem3;
      end else if (top && right) begin
         base = DIR_DOWN;  rem = rem3;
      end else if (bottom && left) begin
         base = DIR_UP;    rem = rem3;
      end else if (bottom && right) begin
         base = DIR_LEFT;  rem = rem3;
      end else if (left) begin
         base = DIR_UP;    rem = rem5;
      end else if (right) begin
         base = DIR_DOWN;  rem = rem5;
      end else if (top) begin
         base = DIR_RIGHT; rem = rem5;
      end else if (bottom) begin
         base = DIR_LEFT;  rem = rem5;
      end else begin
         base = DIR_MID;   rem = rnd[2:0];
      end
      // three-bit add wraps around the eight directions
      return base + rem;
   endfunction

endpackage

`default_nettype wire

FILE: design/gwc_if.sv
// Channel interfaces of the grid random walk block: request, response and
// register write. Depends on gwc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gwc_req_if;
   logic                          valid;
   logic                          ready;
   logic [gwc_pkg::KIND_W-1:0]    kind;
   logic [gwc_pkg::RND_W-1:0]     random_value;
   logic [gwc_pkg::RROW_W-1:0]    read_row;
   logic [gwc_pkg::RCOL_W-1:0]    read_col;

   modport source (output valid, kind, random_value, read_row, read_col, input ready);
   modport sink   (input valid, kind, random_value, read_row, read_col, output ready);
endinterface

interface gwc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gwc_pkg::WROW_W-1:0]    walker_row;
   logic [gwc_pkg::WCOL_W-1:0]    walker_col;
   logic [gwc_pkg::VISIT_W-1:0]   tile_visits;
   logic [gwc_pkg::MOVE_W-1:0]    move_total;
   logic                          all_touched;

   modport source (output valid, walker_row, walker_col, tile_visits, move_total,
                   all_touched, input ready);
   modport sink   (input valid, walker_row, walker_col, tile_visits, move_total,
                   all_touched, output ready);
endinterface

interface gwc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gwc_pkg::CSR_IDX_W-1:0]    index;
   logic [gwc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/grid_random_walk_coverage.sv
// Grid random walk coverage: a walker takes random steps to any of its eight
// neighbors on a grid of up to MAX_ROWS by MAX_COLS tiles, counting visits per
// tile in a single-port-read, single-port-write visit store. Step, read and
// ignored requests pass from acceptance to a loaded response through accept,
// decode and move, store read, read data and count update, and response load,
// which waits while the output register is full; the next request can be taken
// the cycle after the load, and none is taken before it. A start request first
// sweeps the whole store to zero one entry per cycle. After reset the same
// sweep runs before the first request is taken; register writes are taken on
// any cycle. A finished response waits in an output register while the block
// goes back for the next request.
// Depends on gwc_pkg, gwc_if, gwc_ctrl, gwc_dpath and gwc_ram.
`timescale 1ns / 1ps
`default_nettype none

module grid_random_walk_coverage #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 32
) (
   input  logic             clock,
   input  logic             reset,
   gwc_req_if.sink          req_if,
   gwc_rsp_if.source        rsp_if,
   gwc_csr_if.sink          csr_if
);

   gwc_pkg::cmd_type    cmd;
   gwc_pkg::status_type status;
   logic                req_ready;
   logic                csr_we;

   // register port never stalls
   assign csr_if.ready = 1'b1;
   assign csr_we       = csr_if.valid && csr_if.ready;
   assign req_if.ready = req_ready;

   gwc_ctrl u_gwc_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gwc_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_gwc_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_if.kind),
      .req_random_value (req_if.random_value),
      .req_read_row     (req_if.read_row),
      .req_read_col     (req_if.read_col),
      .csr_we           (csr_we),
      .csr_index        (csr_if.index),
      .csr_data         (csr_if.data),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_walker_row   (rsp_if.walker_row),
      .rsp_walker_col   (rsp_if.walker_col),
      .rsp_tile_visits  (rsp_if.tile_visits),
      .rsp_move_total   (rsp_if.move_total),
      .rsp_all_touched  (rsp_if.all_touched)
   );

endmodule

`default_nettype wire

FILE: design/gwc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gwc_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/gwc_ctrl.sv
// Controller of the grid random walk block: sequences clearing sweeps, walker
// moves, visit store accesses and response loads. Depends on gwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gwc_pkg::status_type  status,
   output gwc_pkg::cmd_type     cmd
);

   gwc_pkg::state_type state_ff;
   gwc_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gwc_pkg::S_BOOT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         gwc_pkg::S_BOOT_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.sweep_last) begin
               state_in = gwc_pkg::S_IDLE;
            end
         end
         gwc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = gwc_pkg::S_DECODE;
            end
         end
         gwc_pkg::S_DECODE: begin
            if (status.is_start) begin
               cmd.start_en = 1'b1;
               state_in     = gwc_pkg::S_START_CLEAR;
            end else begin
               // a live step moves now; ignored steps and reads only look up
               cmd.move_en = status.count_item;
               state_in    = gwc_pkg::S_FETCH;
            end
         end
         gwc_pkg::S_START_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.sweep_last) begin
               state_in = gwc_pkg::S_FETCH;
            end
         end
         gwc_pkg::S_FETCH: begin
            cmd.fetch_en = 1'b1;
            state_in     = gwc_pkg::S_LOOK;
         end
         gwc_pkg::S_LOOK: begin
            cmd.look_en  = 1'b1;
            cmd.count_en = status.count_item;
            state_in     = gwc_pkg::S_SEND;
         end
         gwc_pkg::S_SEND: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = gwc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gwc_pkg::S_BOOT_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/gwc_dpath.sv
// Datapath of the grid random walk block: registers, grid geometry, walker
// position, counters, visit store and response register. Depends on gwc_pkg
// and gwc_ram.
`timescale 1ns / 1ps
`default_nettype none

module gwc_dpath #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gwc_pkg::cmd_type                  cmd,
   output gwc_pkg::status_type               status,
   // request payload
   input  logic [gwc_pkg::KIND_W-1:0]        req_kind,
   input  logic [gwc_pkg::RND_W-1:0]         req_random_value,
   input  logic [gwc_pkg::RROW_W-1:0]        req_read_row,
   input  logic [gwc_pkg::RCOL_W-1:0]        req_read_col,
   // register writes
   input  logic                              csr_we,
   input  logic [gwc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gwc_pkg::CSR_DATA_W-1:0]    csr_data,
   // response register
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [gwc_pkg::WROW_W-1:0]        rsp_walker_row,
   output logic [gwc_pkg::WCOL_W-1:0]        rsp_walker_col,
   output logic [gwc_pkg::VISIT_W-1:0]       rsp_tile_visits,
   output logic [gwc_pkg::MOVE_W-1:0]        rsp_move_total,
   output logic                              rsp_all_touched
);

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int UW    = $clog2(DEPTH + 1);
   localparam int GW    = gwc_pkg::GEO_W;
   localparam int SW    = GW + 1;
   localparam int LW    = 2 * GW;
   localparam int VW    = gwc_pkg::VISIT_W;
   localparam int MW    = gwc_pkg::MOVE_W;

   localparam logic [GW-1:0] MAX_ROWS_G = GW'(MAX_ROWS);
   localparam logic [GW-1:0] MAX_COLS_G = GW'(MAX_COLS);
   localparam logic [GW-1:0] GRID_MIN_G = GW'(gwc_pkg::GRID_MIN);

   // grid latched at reset: clamped reset sizes
   localparam int RESET_ROWS = (gwc_pkg::ROW_COUNT_RESET > MAX_ROWS) ?
                               MAX_ROWS : gwc_pkg::ROW_COUNT_RESET;
   localparam int RESET_COLS = (gwc_pkg::COL_COUNT_RESET > MAX_COLS) ?
                               MAX_COLS : gwc_pkg::COL_COUNT_RESET;
   localparam logic [RW-1:0] RESET_LAST_ROW = RW'(RESET_ROWS - 1);
   localparam logic [CW-1:0] RESET_LAST_COL = CW'(RESET_COLS - 1);
   localparam logic [AW-1:0] LAST_ADDR      = AW'(DEPTH - 1);

   // configuration registers
   logic [gwc_pkg::ROW_COUNT_W-1:0] row_count_ff, row_count_in;
   logic [gwc_pkg::COL_COUNT_W-1:0] col_count_ff, col_count_in;
   logic [gwc_pkg::START_ROW_W-1:0] start_row_ff, start_row_in;
   logic [gwc_pkg::START_COL_W-1:0] start_col_ff, start_col_in;

   // walk state
   logic [RW-1:0] last_row_ff, last_row_in;
   logic [CW-1:0] last_col_ff, last_col_in;
   logic [RW-1:0] walker_row_ff, walker_row_in;
   logic [CW-1:0] walker_col_ff, walker_col_in;
   logic [MW-1:0] moves_ff, moves_in;
   logic [UW-1:0] unvisited_ff, unvisited_in;
   logic          finished_ff, finished_in;
   logic          active_ff, active_in;
   logic [AW-1:0] clear_cnt_ff, clear_cnt_in;

   // captured request
   logic [gwc_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [gwc_pkg::RND_W-1:0]  rnd_ff, rnd_in;
   logic [gwc_pkg::RROW_W-1:0] read_row_ff, read_row_in;
   logic [gwc_pkg::RCOL_W-1:0] read_col_ff, read_col_in;
   logic [VW-1:0]              visits_ff, visits_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gwc_pkg::WROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [gwc_pkg::WCOL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [VW-1:0]                 rsp_visits_ff, rsp_visits_in;
   logic [MW-1:0]                 rsp_moves_ff, rsp_moves_in;
   logic                          rsp_touched_ff, rsp_touched_in;

   // combinational helpers
   logic [GW-1:0]        rows_raw, cols_raw, rows_clamp, cols_clamp;
   logic [GW-1:0]        last_row_g, last_col_g, start_row_g, start_col_g;
   logic [LW-1:0]        tile_total;
   logic                 at_top, at_bottom, at_left, at_right;
   logic [2:0]           dir;
   logic signed [SW-1:0] next_row, next_col;
   logic                 is_start, is_step, is_read;
   logic                 count_item, read_in_grid;
   logic [AW-1:0]        walker_addr, read_addr;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr, mem_rd_addr;
   logic [VW-1:0]        mem_wr_data, mem_rd_data;
   logic [VW-1:0]        visit_sat;
   logic [UW-1:0]        unvisited_dec;

   // linear store address of a tile
   function automatic logic [AW-1:0] tile_addr(input logic [GW-1:0] r,
                                               input logic [GW-1:0] c);
      logic [LW-1:0] lin;
      lin = LW'(r) * LW'(MAX_COLS) + LW'(c);
      return lin[AW-1:0];
   endfunction

   // request decode
   assign is_start   = kind_ff == gwc_pkg::KIND_START;
   assign is_step    = kind_ff == gwc_pkg::KIND_STEP;
   assign is_read    = kind_ff == gwc_pkg::KIND_READ;
   assign count_item = is_start || (is_step && active_ff && !finished_ff);

   // grid size clamp and start tile clamp, from the registers
   always_comb begin
      rows_raw = GW'(row_count_ff);
      cols_raw = GW'(col_count_ff);
      if (rows_raw < GRID_MIN_G) begin
         rows_clamp = GRID_MIN_G;
      end else if (rows_raw > MAX_ROWS_G) begin
         rows_clamp = MAX_ROWS_G;
      end else begin
         rows_clamp = rows_raw;
      end
      if (cols_raw < GRID_MIN_G) begin
         cols_clamp = GRID_MIN_G;
      end else if (cols_raw > MAX_COLS_G) begin
         cols_clamp = MAX_COLS_G;
      end else begin
         cols_clamp = cols_raw;
      end
      last_row_g  = rows_clamp - GW'(1);
      last_col_g  = cols_clamp - GW'(1);
      start_row_g = (GW'(start_row_ff) > last_row_g) ? last_row_g : GW'(start_row_ff);
      start_col_g = (GW'(start_col_ff) > last_col_g) ? last_col_g : GW'(start_col_ff);
      tile_total  = LW'(rows_clamp) * LW'(cols_clamp);
   end

   // tile class and next walker tile
   assign at_top    = walker_row_ff == '0;
   assign at_bottom = walker_row_ff == last_row_ff;
   assign at_left   = walker_col_ff == '0;
   assign at_right  = walker_col_ff == last_col_ff;
   assign dir       = gwc_pkg::pick_dir(at_top, at_bottom, at_left, at_right, rnd_ff);
   assign next_row  = $signed({1'b0, GW'(walker_row_ff)}) + SW'(gwc_pkg::ROW_DELTA[dir]);
   assign next_col  = $signed({1'b0, GW'(walker_col_ff)}) + SW'(gwc_pkg::COL_DELTA[dir]);

   // store addresses and read bounds
   assign walker_addr  = tile_addr(GW'(walker_row_ff), GW'(walker_col_ff));
   assign read_addr    = tile_addr(GW'(read_row_ff), GW'(read_col_ff));
   assign read_in_grid = (GW'(read_row_ff) <= GW'(last_row_ff)) &&
                         (GW'(read_col_ff) <= GW'(last_col_ff));

   // visit update values
   assign visit_sat     = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + VW'(1);
   assign unvisited_dec = (mem_rd_data == '0 && unvisited_ff != '0) ?
                          unvisited_ff - UW'(1) : unvisited_ff;

   // visit store
   assign mem_wr_en   = cmd.clear_en || cmd.count_en;
   assign mem_wr_addr = cmd.clear_en ? clear_cnt_ff : walker_addr;
   assign mem_wr_data = cmd.clear_en ? '0 : visit_sat;
   assign mem_rd_addr = is_read ? read_addr : walker_addr;

   gwc_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_visit_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (cmd.fetch_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // register writes
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      start_row_in = start_row_ff;
      start_col_in = start_col_ff;
      if (csr_we) begin
         unique case (gwc_pkg::csr_index_type'(csr_index))
            gwc_pkg::REG_ROW_COUNT: row_count_in = csr_data[gwc_pkg::ROW_COUNT_W-1:0];
            gwc_pkg::REG_COL_COUNT: col_count_in = csr_data[gwc_pkg::COL_COUNT_W-1:0];
            gwc_pkg::REG_START_ROW: start_row_in = csr_data[gwc_pkg::START_ROW_W-1:0];
            gwc_pkg::REG_START_COL: start_col_in = csr_data[gwc_pkg::START_COL_W-1:0];
            default: begin
               row_count_in = row_count_ff;
            end
         endcase
      end
   end

   // walk state updates
   always_comb begin
      last_row_in   = last_row_ff;
      last_col_in   = last_col_ff;
      walker_row_in = walker_row_ff;
      walker_col_in = walker_col_ff;
      moves_in      = moves_ff;
      unvisited_in  = unvisited_ff;
      finished_in   = finished_ff;
      active_in     = active_ff;
      clear_cnt_in  = clear_cnt_ff;
      kind_in       = kind_ff;
      rnd_in        = rnd_ff;
      read_row_in   = read_row_ff;
      read_col_in   = read_col_ff;
      visits_in     = visits_ff;

      if (cmd.take) begin
         kind_in     = req_kind;
         rnd_in      = req_random_value;
         read_row_in = req_read_row;
         read_col_in = req_read_col;
      end

      // sweep address wraps so every sweep starts at entry zero
      if (cmd.clear_en) begin
         clear_cnt_in = (clear_cnt_ff == LAST_ADDR) ? '0 : clear_cnt_ff + AW'(1);
      end

      if (cmd.start_en) begin
         last_row_in   = last_row_g[RW-1:0];
         last_col_in   = last_col_g[CW-1:0];
         walker_row_in = start_row_g[RW-1:0];
         walker_col_in = start_col_g[CW-1:0];
         moves_in      = '0;
         unvisited_in  = tile_total[UW-1:0];
         finished_in   = 1'b0;
         active_in     = 1'b1;
      end

      if (cmd.move_en) begin
         walker_row_in = next_row[RW-1:0];
         walker_col_in = next_col[CW-1:0];
      end

      if (cmd.look_en) begin
         if (cmd.count_en) begin
            visits_in = visit_sat;
         end else if (is_read && !read_in_grid) begin
            visits_in = '0;
         end else begin
            visits_in = mem_rd_data;
         end
      end

      if (cmd.count_en) begin
         unvisited_in = unvisited_dec;
         finished_in  = unvisited_dec == '0;
         if (is_step && moves_ff != '1) begin
            moves_in = moves_ff + MW'(1);
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_visits_in  = rsp_visits_ff;
      rsp_moves_in   = rsp_moves_ff;
      rsp_touched_in = rsp_touched_ff;
      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_row_in     = gwc_pkg::WROW_W'(walker_row_ff);
         rsp_col_in     = gwc_pkg::WCOL_W'(walker_col_ff);
         rsp_visits_in  = visits_ff;
         rsp_moves_in   = moves_ff;
         rsp_touched_in = finished_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and walk state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= gwc_pkg::ROW_COUNT_W'(gwc_pkg::ROW_COUNT_RESET);
         col_count_ff  <= gwc_pkg::COL_COUNT_W'(gwc_pkg::COL_COUNT_RESET);
         start_row_ff  <= gwc_pkg::START_ROW_W'(gwc_pkg::START_ROW_RESET);
         start_col_ff  <= gwc_pkg::START_COL_W'(gwc_pkg::START_COL_RESET);
         last_row_ff   <= RESET_LAST_ROW;
         last_col_ff   <= RESET_LAST_COL;
         walker_row_ff <= '0;
         walker_col_ff <= '0;
         moves_ff      <= '0;
         unvisited_ff  <= '0;
         finished_ff   <= 1'b0;
         active_ff     <= 1'b0;
         clear_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         start_row_ff  <= start_row_in;
         start_col_ff  <= start_col_in;
         last_row_ff   <= last_row_in;
         last_col_ff   <= last_col_in;
         walker_row_ff <= walker_row_in;
         walker_col_ff <= walker_col_in;
         moves_ff      <= moves_in;
         unvisited_ff  <= unvisited_in;
         finished_ff   <= finished_in;
         active_ff     <= active_in;
         clear_cnt_ff  <= clear_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      rnd_ff         <= rnd_in;
      read_row_ff    <= read_row_in;
      read_col_ff    <= read_col_in;
      visits_ff      <= visits_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_visits_ff  <= rsp_visits_in;
      rsp_moves_ff   <= rsp_moves_in;
      rsp_touched_ff <= rsp_touched_in;
   end

   // status to the controller
   assign status.is_start   = is_start;
   assign status.count_item = count_item;
   assign status.sweep_last = clear_cnt_ff == LAST_ADDR;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_walker_row  = rsp_row_ff;
   assign rsp_walker_col  = rsp_col_ff;
   assign rsp_tile_visits = rsp_visits_ff;
   assign rsp_move_total  = rsp_moves_ff;
   assign rsp_all_touched = rsp_touched_ff;

endmodule

`default_nettype wire

FILE: design/gwc_checker.sv
// Port-level checker of the grid random walk block and its bind to the top
// level. Depends on gwc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gwc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [gwc_pkg::WROW_W-1:0]      rsp_walker_row,
   input logic [gwc_pkg::WCOL_W-1:0]      rsp_walker_col,
   input logic [gwc_pkg::VISIT_W-1:0]     rsp_tile_visits,
   input logic [gwc_pkg::MOVE_W-1:0]      rsp_move_total,
   input logic                            rsp_all_touched
);

   // a stalled response stays offered
   `GWC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // a stalled response keeps its payload
   `GWC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_walker_row) && $stable(rsp_walker_col) && $stable(rsp_tile_visits) && $stable(rsp_move_total) && $stable(rsp_all_touched))

   // one request at a time: ready drops right after a request is taken
   `GWC_ASSERT(a_one_request, clock, reset, req_valid && req_ready |=> !req_ready)

   // the clearing sweep after reset holds off requests
   `GWC_ASSERT_NR(a_boot_sweep, clock, $fell(reset) |-> !req_ready)

endmodule

bind grid_random_walk_coverage gwc_checker u_gwc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_walker_row  (rsp_if.walker_row),
   .rsp_walker_col  (rsp_if.walker_col),
   .rsp_tile_visits (rsp_if.tile_visits),
   .rsp_move_total  (rsp_if.move_total),
   .rsp_all_touched (rsp_if.all_touched)
);

`default_nettype wire
